@@ rtl/qrk_pkg.sv @@
package qrk_pkg;

  // Saturation limits
  localparam logic signed [63:0] Q_LIMIT = 64'sd2147483647;
  localparam logic signed [63:0] K_LIMIT = 64'sd70368744177663;

  // Reset value of the time step register (about 1 ms)
  localparam logic [31:0] STEP_TIME_RESET = 32'd4294967;

  // Action codes
  localparam logic [1:0] ACT_INTEGRATE = 2'd0;
  localparam logic [1:0] ACT_LOAD      = 2'd1;

  // One product term of the derivative
  typedef struct packed {
    logic [1:0] ridx;
    logic [1:0] qidx;
    logic       neg;
  } term_t;

  // Select rate and quaternion components for term trm of component cmp
  function automatic term_t term_sel(input logic [1:0] cmp, input logic [1:0] trm);
    term_t t;
    t = '0;
    unique case ({cmp, trm})
      4'h0: t = '{ridx: 2'd0, qidx: 2'd1, neg: 1'b1};
      4'h1: t = '{ridx: 2'd1, qidx: 2'd2, neg: 1'b1};
      4'h2: t = '{ridx: 2'd2, qidx: 2'd3, neg: 1'b1};
      4'h4: t = '{ridx: 2'd0, qidx: 2'd0, neg: 1'b0};
      4'h5: t = '{ridx: 2'd1, qidx: 2'd3, neg: 1'b0};
      4'h6: t = '{ridx: 2'd2, qidx: 2'd2, neg: 1'b1};
      4'h8: t = '{ridx: 2'd1, qidx: 2'd0, neg: 1'b0};
      4'h9: t = '{ridx: 2'd2, qidx: 2'd1, neg: 1'b0};
      4'ha: t = '{ridx: 2'd0, qidx: 2'd3, neg: 1'b1};
      4'hc: t = '{ridx: 2'd2, qidx: 2'd0, neg: 1'b0};
      4'hd: t = '{ridx: 2'd0, qidx: 2'd2, neg: 1'b0};
      4'he: t = '{ridx: 2'd1, qidx: 2'd1, neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

  // Clamp to a quaternion component
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > Q_LIMIT) r = Q_LIMIT;
    if (v < -Q_LIMIT) r = -Q_LIMIT;
    return r[31:0];
  endfunction

  // Clamp to the derivative range
  function automatic logic signed [46:0] sat_k(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > K_LIMIT) r = K_LIMIT;
    if (v < -K_LIMIT) r = -K_LIMIT;
    return r[46:0];
  endfunction

endpackage

@@ rtl/quaternion_rk4_attitude_step_core.sv @@
// Quaternion attitude integrator, one fourth-order Runge-Kutta step per item.
// Input channel (in_valid/in_ready): action, body rates and a quaternion to
// load. Result channel (out_valid/out_ready): the current quaternion and a
// flag that is set when an integrate step collapsed to zero length and the
// identity was substituted. cfg_we/cfg_wdata write the time step (Q0.32 s).
// The block takes one transaction at a time; in_ready is high only while idle.
// An integrate runs four derivative stages (20 products each through one
// shared 33x33 multiplier), four divide-by-six steps (four 13-bit digits
// each by reciprocal multiplication), the squared length, the bit-pair square
// root and four normalizing divisions (32 steps each), then loads the output
// register. A step that collapses to zero length skips the root and the
// divisions. Load and hold go straight to the output register, and in_ready
// rises together with out_valid. An output register parts the two sides, so
// a new transaction is accepted while a result waits; a finished result then
// waits until the register is free. Reset restores the identity quaternion
// and the 1 ms time step, and drops any pending result.
module quaternion_rk4_attitude_step_core
  import qrk_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 30,
  parameter int RATE_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic signed [31:0] in_load_w,
  input  logic signed [31:0] in_load_x,
  input  logic signed [31:0] in_load_y,
  input  logic signed [31:0] in_load_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic               out_was_degenerate
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DMUL = 4'd1;
  localparam logic [3:0] S_DACC = 4'd2;
  localparam logic [3:0] S_STUP = 4'd3;
  localparam logic [3:0] S_D6   = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_FADD = 4'd6;
  localparam logic [3:0] S_SQM  = 4'd7;
  localparam logic [3:0] S_SQA  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_NSET = 4'd10;
  localparam logic [3:0] S_NFIN = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_DSIX = 4'd13;

  localparam logic signed [31:0] IDENT_W = 32'(64'sd1 <<< QUAT_FRAC_BITS);

  logic [3:0]         state_r;
  logic [31:0]        step_time_r;
  logic signed [31:0] q_r [4];
  logic signed [31:0] st_r [4];
  logic signed [31:0] rate_r [3];
  logic signed [48:0] dk_r [4];
  logic signed [51:0] dsum_r [4];
  logic signed [46:0] k_r;
  logic [31:0]        lo_r;
  logic signed [63:0] acc_r;
  logic signed [65:0] prod_r;
  logic [1:0]         stg_r;
  logic [1:0]         cmp_r;
  logic [2:0]         trm_r;
  logic               degen_r;

  logic [32:0]        rem_r;
  logic [63:0]        nsh_r;
  logic [63:0]        quo_r;
  logic [6:0]         dcnt_r;
  logic [31:0]        den_r;

  logic [63:0]        ss_r;
  logic [63:0]        sv_r;
  logic [63:0]        sres_r;
  logic [63:0]        sbit_r;
  logic [31:0]        len_r;

  logic               out_valid_r;
  logic signed [31:0] out_w_r, out_x_r, out_y_r, out_z_r;
  logic               out_deg_r;

  term_t              ts;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] term;
  logic signed [63:0] acc_base;
  logic signed [63:0] acc_nxt;
  logic signed [48:0] dk_nxt;
  logic signed [51:0] dsum_abs;
  logic [51:0]        six_num;
  logic [15:0]        six_v;
  logic [31:0]        six_p;
  logic [12:0]        six_qd;
  logic [2:0]         six_rm;
  logic [31:0]        nq_mag;
  logic [63:0]        norm_num;
  logic [33:0]        div_t;
  logic               div_ge;
  logic [32:0]        rem_nxt;
  logic [63:0]        quo_nxt;
  logic [63:0]        ss_nxt;
  logic [64:0]        sq_sum;
  logic               sq_ge;
  logic [63:0]        sv_nxt;
  logic [63:0]        sres_nxt;
  logic [31:0]        clamp;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;

  // Select operands of the shared multiplier
  always_comb begin
    ts    = term_sel(cmp_r, trm_r[1:0]);
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQM) begin
      mul_a = {st_r[cmp_r][31], st_r[cmp_r]};
      mul_b = {st_r[cmp_r][31], st_r[cmp_r]};
    end else if (trm_r < 3'd3) begin
      mul_a = {rate_r[ts.ridx][31], rate_r[ts.ridx]};
      mul_b = {st_r[ts.qidx][31], st_r[ts.qidx]};
    end else if (trm_r == 3'd3) begin
      mul_a = {1'b0, k_r[31:0]};
      mul_b = {1'b0, step_time_r};
    end else begin
      mul_a = {{18{k_r[46]}}, k_r[46:32]};
      mul_b = {1'b0, step_time_r};
    end
  end

  // Derivative accumulation and time-step scaling
  always_comb begin
    term     = 64'(prod_r >>> RATE_FRAC_BITS);
    acc_base = (trm_r == 3'd0) ? 64'sd0 : acc_r;
    acc_nxt  = ts.neg ? (acc_base - term) : (acc_base + term);
    dk_nxt   = 49'(prod_r + $signed({34'd0, lo_r}));
  end

  // Numerators for the divide-by-six and the normalizing divider
  always_comb begin
    dsum_abs = dsum_r[cmp_r][51] ? -dsum_r[cmp_r] : dsum_r[cmp_r];
    six_num  = $unsigned(dsum_abs) + 52'd3;
    nq_mag   = st_r[cmp_r][31] ? 32'(-st_r[cmp_r]) : 32'(st_r[cmp_r]);
    norm_num = ({32'd0, nq_mag} << QUAT_FRAC_BITS) + {33'd0, len_r[31:1]};
  end

  // One 13-bit digit of the divide-by-six: floor(v/6) = (v*87382) >> 19
  always_comb begin
    six_v  = {rem_r[2:0], nsh_r[63:51]};
    six_p  = 32'(six_v) * 32'd87382;
    six_qd = six_p[31:19];
    six_rm = 3'(six_v - (16'(six_qd) * 16'd6));
  end

  // Restoring divider step
  always_comb begin
    div_t   = {rem_r, nsh_r[63]};
    div_ge  = (div_t >= {2'b00, den_r});
    rem_nxt = div_ge ? 33'(div_t - {2'b00, den_r}) : div_t[32:0];
    quo_nxt = {quo_r[62:0], div_ge};
    clamp   = (quo_r > 64'h7fff_ffff) ? 32'h7fff_ffff : quo_r[31:0];
  end

  // Squared length and square root step
  always_comb begin
    ss_nxt   = ss_r + 64'(prod_r);
    sq_sum   = {1'b0, sres_r} + {1'b0, sbit_r};
    sq_ge    = ({1'b0, sv_r} >= sq_sum);
    sv_nxt   = sq_ge ? (sv_r - sq_sum[63:0]) : sv_r;
    sres_nxt = sq_ge ? ((sres_r >> 1) + sbit_r) : (sres_r >> 1);
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_time_r <= STEP_TIME_RESET;
      q_r[0]      <= IDENT_W;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
      out_valid_r <= 1'b0;
      degen_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_time_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            degen_r <= 1'b0;
            if (in_action == ACT_INTEGRATE) begin
              rate_r[0] <= in_rate_x;
              rate_r[1] <= in_rate_y;
              rate_r[2] <= in_rate_z;
              for (int i = 0; i < 4; i++) begin
                st_r[i]   <= q_r[i];
                dsum_r[i] <= '0;
              end
              stg_r   <= '0;
              cmp_r   <= '0;
              trm_r   <= '0;
              state_r <= S_DMUL;
            end else begin
              if (in_action == ACT_LOAD) begin
                q_r[0] <= in_load_w;
                q_r[1] <= in_load_x;
                q_r[2] <= in_load_y;
                q_r[3] <= in_load_z;
              end
              state_r <= S_FIN;
            end
          end
        end

        S_DMUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_DACC;
        end

        S_DACC: begin
          if (trm_r < 3'd3) begin
            acc_r   <= acc_nxt;
            trm_r   <= trm_r + 3'd1;
            state_r <= S_DMUL;
            if (trm_r == 3'd2) begin
              k_r <= sat_k(acc_nxt >>> 1);
            end
          end else if (trm_r == 3'd3) begin
            lo_r    <= prod_r[63:32];
            trm_r   <= trm_r + 3'd1;
            state_r <= S_DMUL;
          end else begin
            // Keep this stage's increment and add it to the weighted sum
            dk_r[cmp_r] <= dk_nxt;
            if (stg_r == 2'd1 || stg_r == 2'd2) begin
              dsum_r[cmp_r] <= dsum_r[cmp_r] + (52'(dk_nxt) <<< 1);
            end else begin
              dsum_r[cmp_r] <= dsum_r[cmp_r] + 52'(dk_nxt);
            end
            trm_r   <= '0;
            cmp_r   <= cmp_r + 2'd1;
            state_r <= (cmp_r == 2'd3) ? S_STUP : S_DMUL;
          end
        end

        S_STUP: begin
          if (stg_r == 2'd3) begin
            cmp_r   <= '0;
            state_r <= S_D6;
          end else begin
            // Build the next stage quaternion
            for (int i = 0; i < 4; i++) begin
              if (stg_r == 2'd2) begin
                st_r[i] <= sat_q(64'(q_r[i]) + 64'(dk_r[i]));
              end else begin
                st_r[i] <= sat_q(64'(q_r[i]) + 64'(dk_r[i] >>> 1));
              end
            end
            stg_r   <= stg_r + 2'd1;
            cmp_r   <= '0;
            trm_r   <= '0;
            state_r <= S_DMUL;
          end
        end

        S_D6: begin
          rem_r   <= '0;
          nsh_r   <= {six_num, 12'd0};
          quo_r   <= '0;
          dcnt_r  <= 7'd4;
          state_r <= S_DSIX;
        end

        S_DSIX: begin
          // Advance the divide-by-six one digit
          rem_r  <= {30'd0, six_rm};
          nsh_r  <= {nsh_r[50:0], 13'd0};
          quo_r  <= {quo_r[50:0], six_qd};
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == 7'd1) begin
            state_r <= S_FADD;
          end
        end

        S_DIV: begin
          rem_r  <= rem_nxt;
          nsh_r  <= {nsh_r[62:0], 1'b0};
          quo_r  <= quo_nxt;
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == 7'd1) begin
            state_r <= S_NFIN;
          end
        end

        S_FADD: begin
          if (dsum_r[cmp_r][51]) begin
            st_r[cmp_r] <= sat_q(64'(q_r[cmp_r]) - $signed(quo_r));
          end else begin
            st_r[cmp_r] <= sat_q(64'(q_r[cmp_r]) + $signed(quo_r));
          end
          cmp_r <= cmp_r + 2'd1;
          if (cmp_r == 2'd3) begin
            ss_r    <= '0;
            state_r <= S_SQM;
          end else begin
            state_r <= S_D6;
          end
        end

        S_SQM: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_SQA;
        end

        S_SQA: begin
          ss_r  <= ss_nxt;
          cmp_r <= cmp_r + 2'd1;
          if (cmp_r != 2'd3) begin
            state_r <= S_SQM;
          end else if (ss_nxt == 64'd0) begin
            // Zero length: fall back to the identity
            q_r[0]  <= IDENT_W;
            q_r[1]  <= '0;
            q_r[2]  <= '0;
            q_r[3]  <= '0;
            degen_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            sv_r    <= ss_nxt;
            sres_r  <= '0;
            sbit_r  <= 64'h4000_0000_0000_0000;
            state_r <= S_SQRT;
          end
        end

        S_SQRT: begin
          sv_r   <= sv_nxt;
          sres_r <= sres_nxt;
          sbit_r <= sbit_r >> 2;
          if (sbit_r[0]) begin
            len_r   <= sres_nxt[31:0];
            cmp_r   <= '0;
            state_r <= S_NSET;
          end
        end

        S_NSET: begin
          rem_r   <= {1'b0, norm_num[63:32]};
          nsh_r   <= {norm_num[31:0], 32'd0};
          quo_r   <= '0;
          den_r   <= len_r;
          dcnt_r  <= 7'd32;
          state_r <= S_DIV;
        end

        S_NFIN: begin
          q_r[cmp_r] <= st_r[cmp_r][31] ? -$signed(clamp) : $signed(clamp);
          cmp_r      <= cmp_r + 2'd1;
          state_r    <= (cmp_r == 2'd3) ? S_FIN : S_NSET;
        end

        S_FIN: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_w_r     <= q_r[0];
            out_x_r     <= q_r[1];
            out_y_r     <= q_r[2];
            out_z_r     <= q_r[3];
            out_deg_r   <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quat_w         = out_w_r;
  assign out_quat_x         = out_x_r;
  assign out_quat_y         = out_y_r;
  assign out_quat_z         = out_z_r;
  assign out_was_degenerate = out_deg_r;

endmodule

@@ test/attitude_checker.sv @@
module attitude_checker
  import qrk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_rate_x,
  input  logic signed [31:0] in_rate_y,
  input  logic signed [31:0] in_rate_z,
  input  logic signed [31:0] in_load_w,
  input  logic signed [31:0] in_load_x,
  input  logic signed [31:0] in_load_y,
  input  logic signed [31:0] in_load_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_quat_w,
  input  logic signed [31:0] out_quat_x,
  input  logic signed [31:0] out_quat_y,
  input  logic signed [31:0] out_quat_z,
  input  logic               out_was_degenerate,
  output int                 fail_count,
  output int                 pending,
  output int                 steps_seen,
  output int                 degen_seen
);

  localparam int QF = 30;
  localparam int RF = 16;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               degen;
  } attitude_t;

  attitude_t expected_q[$];
  logic signed [63:0] model_q [4];
  logic [31:0] model_dt;

  // Floor shift of a signed value
  function automatic logic signed [63:0] fsr(input logic signed [63:0] v, input int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [63:0] rdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scale a derivative by the time step, floor of k*dt/2^32
  function automatic logic signed [63:0] scale_dt(input logic signed [63:0] k);
    logic signed [63:0] hi, lo;
    hi = {32'd0, 16'd0, model_dt[31:16]};
    lo = {48'd0, model_dt[15:0]};
    return fsr(k * hi + fsr(k * lo, 16), 16);
  endfunction

  // Advance the model orientation one RK4 step; returns 1 on zero length
  function automatic logic rk4_advance(input logic signed [63:0] r0,
                                       input logic signed [63:0] r1,
                                       input logic signed [63:0] r2);
    logic signed [63:0] st [4];
    logic signed [63:0] k [4];
    logic signed [63:0] dk [4][4];
    logic signed [63:0] nq [4];
    logic signed [63:0] a, d;
    logic [63:0] ss, len;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        if (j == 0) st[i] = model_q[i];
        else if (j < 3) st[i] = clamp(model_q[i] + fsr(dk[j-1][i], 1), Q_LIMIT);
        else st[i] = clamp(model_q[i] + dk[2][i], Q_LIMIT);
      end
      a = -fsr(r0 * st[1], RF) - fsr(r1 * st[2], RF) - fsr(r2 * st[3], RF);
      k[0] = clamp(fsr(a, 1), K_LIMIT);
      a = fsr(st[0] * r0, RF) + fsr(r1 * st[3], RF) - fsr(r2 * st[2], RF);
      k[1] = clamp(fsr(a, 1), K_LIMIT);
      a = fsr(st[0] * r1, RF) + fsr(r2 * st[1], RF) - fsr(r0 * st[3], RF);
      k[2] = clamp(fsr(a, 1), K_LIMIT);
      a = fsr(st[0] * r2, RF) + fsr(r0 * st[2], RF) - fsr(r1 * st[1], RF);
      k[3] = clamp(fsr(a, 1), K_LIMIT);
      for (int i = 0; i < 4; i++) dk[j][i] = scale_dt(k[i]);
    end
    ss = 0;
    for (int i = 0; i < 4; i++) begin
      d = dk[0][i] + 2 * dk[1][i] + 2 * dk[2][i] + dk[3][i];
      nq[i] = clamp(model_q[i] + rdiv(d, 6), Q_LIMIT);
      ss = ss + 64'(nq[i] * nq[i]);
    end
    if (ss == 0) begin
      model_q[0] = 64'sd1 <<< QF;
      for (int i = 1; i < 4; i++) model_q[i] = 0;
      return 1'b1;
    end
    len = root64(ss);
    for (int i = 0; i < 4; i++)
      model_q[i] = clamp(rdiv(nq[i] <<< QF, $signed(len)), Q_LIMIT);
    return 1'b0;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    attitude_t e;
    logic dg;
    if (!rst_n) begin
      model_dt <= STEP_TIME_RESET;
      model_q[0] = 64'sd1 <<< QF;
      for (int i = 1; i < 4; i++) model_q[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      steps_seen <= 0;
      degen_seen <= 0;
    end else begin
      // predict on each accepted input transaction
      if (in_valid && in_ready) begin
        dg = 1'b0;
        if (in_action == ACT_INTEGRATE) begin
          dg = rk4_advance(in_rate_x, in_rate_y, in_rate_z);
          steps_seen <= steps_seen + 1;
          if (dg) degen_seen <= degen_seen + 1;
        end else if (in_action == ACT_LOAD) begin
          model_q[0] = in_load_w;
          model_q[1] = in_load_x;
          model_q[2] = in_load_y;
          model_q[3] = in_load_z;
        end
        expected_q.push_back({model_q[0][31:0], model_q[1][31:0], model_q[2][31:0],
                              model_q[3][31:0], dg});
      end
      if (cfg_we) model_dt <= cfg_wdata;
      // compare each result transaction with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.w !== out_quat_w || e.x !== out_quat_x || e.y !== out_quat_y ||
              e.z !== out_quat_z || e.degen !== out_was_degenerate) begin
            if (fail_count < 10)
              $display("ERROR: exp %0d %0d %0d %0d d%0b got %0d %0d %0d %0d d%0b",
                       e.w, e.x, e.y, e.z, e.degen, out_quat_w, out_quat_x,
                       out_quat_y, out_quat_z, out_was_degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
module tb_top
  import qrk_pkg::*;
();

  localparam logic [1:0] ACT_HOLD   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ONE_Q = 1 << 30;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [31:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_action = 0;
  logic signed [31:0] in_rate_x = 0, in_rate_y = 0, in_rate_z = 0;
  logic signed [31:0] in_load_w = 0, in_load_x = 0, in_load_y = 0, in_load_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_was_degenerate;
  int fail_count, pending, steps_seen, degen_seen;
  int sent;
  bit calm;
  int hold_off;

  always #5 clk = ~clk;

  quaternion_rk4_attitude_step_core dut (.*);
  attitude_checker chk (.*);

  // Offer one transaction and hold it until accepted
  task automatic send(input logic [1:0] act, input logic [31:0] rx, ry, rz,
                      input logic [31:0] lw, lx, ly, lz);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_rate_x <= rx; in_rate_y <= ry; in_rate_z <= rz;
    in_load_w <= lw; in_load_x <= lx; in_load_y <= ly; in_load_z <= lz;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic set_step(input logic [31:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Small random rates mostly, sometimes the full range
  function automatic logic [31:0] rnd_rate();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(0, 2000000)) - 1000000;
  endfunction

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 0;
      default: return $signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
    endcase
  endfunction

  // Result side: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_off > 0) begin
      out_ready <= 0;
      hold_off <= hold_off - 1;
    end else out_ready <= calm || ($urandom_range(99) >= 21);
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [31:0] dt_set [5];
    hold_off = 0;
    calm = 0;
    sent = 0;
    dt_set = '{32'd0, 32'hFFFF_FFFF, 32'd4294967, 32'd65536, 32'h1000_0000};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: every action, extremes, degenerate collapse
    send(ACT_INTEGRATE, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
    send(ACT_HOLD, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_UNUSED, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    send(ACT_LOAD, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send(ACT_INTEGRATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_INTEGRATE, 32'h0010_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    send(ACT_LOAD, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000);
    send(ACT_INTEGRATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
    send(ACT_LOAD, 0, 0, 0, 1, 0, 0, 0);
    send(ACT_INTEGRATE, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_LOAD, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0);
    send(ACT_INTEGRATE, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 0);
    // random phases at several time steps, extremes among them
    for (int p = 0; p < 5; p++) begin
      set_step(dt_set[p]);
      calm = (p == 2);
      if (p == 1) hold_off = 2000;
      for (int n = 0; n < 150; n++) begin
        case ($urandom_range(9))
          0, 1: send(ACT_LOAD, rnd_rate(), rnd_rate(), rnd_rate(),
                     rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
          2: send(2'($urandom_range(2, 3)), rnd_rate(), rnd_rate(), rnd_rate(),
                  rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
          default: send(ACT_INTEGRATE, rnd_rate(), rnd_rate(), rnd_rate(),
                        rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
        endcase
      end
      calm = 0;
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    $display("Ran %0d transactions, %0d RK4 steps (%0d collapsed to identity),",
             sent, steps_seen, degen_seen);
    $display("over five time-step settings including zero and full scale.");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
